// ----- hw/rtl/sorted_key_table_lookup_assert.svh -----
// assertion macros for the sorted key table lookup block
`ifndef SORTED_KEY_TABLE_LOOKUP_ASSERT_SVH
`define SORTED_KEY_TABLE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define SKT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("skt assertion failed");
`define SKT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("skt forbidden condition");
`else
`define SKT_ASSERT(lbl, prop)
`define SKT_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- hw/rtl/skt_pkg.sv -----
// shared types and constants for the sorted key table lookup block
package skt_pkg;
  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_SORT  = 2'd1,
    MODE_GET   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_CMP,
    ST_SRCH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;
endpackage

// ----- hw/rtl/skt_cell.sv -----
// one table entry cell: holds a pair, swaps with neighbors, compares to query
module skt_cell (
  input  logic                      clk,
  input  skt_pkg::cell_ctl_t        ctl,
  input  skt_pkg::entry_t           load_data,
  input  skt_pkg::entry_t           left_data,
  input  skt_pkg::entry_t           right_data,
  input  logic [skt_pkg::KEY_W-1:0] q_key,
  output skt_pkg::entry_t           data,
  output logic                      gt,
  output logic                      eq
);
  skt_pkg::entry_t data_r;
  skt_pkg::entry_t data_nxt;
  logic            gt_r;
  logic            eq_r;

  // entry update: append load or neighbor exchange
  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.take_right) begin
      data_nxt = right_data;
    end else if (ctl.take_left) begin
      data_nxt = left_data;
    end
  end

  // stored pair and registered query compare
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    gt_r   <= data_r.key > q_key;
    eq_r   <= data_r.key == q_key;
  end

  assign data = data_r;
  assign gt   = gt_r;
  assign eq   = eq_r;
endmodule

// ----- hw/rtl/sorted_key_table_lookup.sv -----
// sorted key table lookup: put, clear, get and sort requests; one request in flight,
// sort time set by the odd-even exchange over the cell chain, get time by the binary
// search probes over the registered cell compares.
// a new request is taken once the busy phase ends and the output register is free.
// synchronous active-low reset empties the table and clears the output valid flag;
// cell contents and the output data registers are not reset.
`include "sorted_key_table_lookup_assert.svh"
module sorted_key_table_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic        out_found,
  output logic        out_full_dropped
);
  localparam int CAP = skt_pkg::CAPACITY;
  localparam int IW  = skt_pkg::IDX_W;
  localparam int CW  = skt_pkg::CNT_W;

  skt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   pass_r, pass_nxt;
  logic            par_r, par_nxt;
  logic [31:0]     q_key_r, q_key_nxt;
  logic signed [CW:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic            ov_r, ov_nxt;
  logic [31:0]     ores_r, ores_nxt;
  logic            ofnd_r, ofnd_nxt;
  logic            odrp_r, odrp_nxt;

  skt_pkg::entry_t   cell_data [CAP];
  skt_pkg::cell_ctl_t cell_ctl [CAP];
  logic [CAP-1:0]    gt_v, eq_v, swap_v;
  skt_pkg::entry_t   load_data;
  logic              accept;
  logic signed [CW:0] mid;
  logic [IW-1:0]     mid_idx;

  assign load_data = '{key: in_key, val: in_value};
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != skt_pkg::ST_IDLE) || (ov_r && out_stall);

  // exchange decision for each neighbor pair in the sort phase
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      swap_v[i] = 1'b0;
      if (i < CAP - 1) begin
        swap_v[i] = (state_r == skt_pkg::ST_SORT) && (i[0] == par_r) &&
                    ((i + 1) < int'(cnt_r)) && (cell_data[i].key > cell_data[i+1].key);
      end
    end
  end

  // cell controls
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_ctl[i].load = accept && (in_mode == skt_pkg::MODE_PUT) &&
                         (int'(cnt_r) == i);
      cell_ctl[i].take_right = swap_v[i];
      cell_ctl[i].take_left  = (i > 0) ? swap_v[(i > 0) ? i - 1 : 0] : 1'b0;
    end
  end

  // the cell chain
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    skt_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .load_data  (load_data),
      .left_data  (cell_data[(g > 0) ? g - 1 : g]),
      .right_data (cell_data[(g < CAP - 1) ? g + 1 : g]),
      .q_key      (q_key_r),
      .data       (cell_data[g]),
      .gt         (gt_v[g]),
      .eq         (eq_v[g])
    );
  end

  // probe position
  assign mid     = lo_r + ((hi_r - lo_r) >>> 1);
  assign mid_idx = mid[IW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    par_nxt   = par_r;
    q_key_nxt = q_key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ov_nxt    = ov_r && out_stall;
    ores_nxt  = ores_r;
    ofnd_nxt  = ofnd_r;
    odrp_nxt  = odrp_r;
    case (state_r)
      skt_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            skt_pkg::MODE_PUT: begin
              ov_nxt   = 1'b1;
              ores_nxt = '0;
              ofnd_nxt = 1'b0;
              odrp_nxt = (int'(cnt_r) >= CAP);
              if (int'(cnt_r) < CAP) begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            skt_pkg::MODE_SORT: begin
              state_nxt = skt_pkg::ST_SORT;
              pass_nxt  = '0;
              par_nxt   = 1'b0;
            end
            skt_pkg::MODE_GET: begin
              state_nxt = skt_pkg::ST_CMP;
              q_key_nxt = in_key;
              lo_nxt    = '0;
              hi_nxt    = $signed({1'b0, cnt_r}) - (CW+1)'(1);
            end
            default: begin
              cnt_nxt  = '0;
              ov_nxt   = 1'b1;
              ores_nxt = '0;
              ofnd_nxt = 1'b0;
              odrp_nxt = 1'b0;
            end
          endcase
        end
      end
      skt_pkg::ST_SORT: begin
        par_nxt  = !par_r;
        pass_nxt = pass_r + CW'(1);
        if (int'(pass_r) == CAP - 1) begin
          state_nxt = skt_pkg::ST_IDLE;
          ov_nxt    = 1'b1;
          ores_nxt  = '0;
          ofnd_nxt  = 1'b0;
          odrp_nxt  = 1'b0;
        end
      end
      skt_pkg::ST_CMP: begin
        state_nxt = skt_pkg::ST_SRCH;
      end
      skt_pkg::ST_SRCH: begin
        if (lo_r > hi_r) begin
          state_nxt = skt_pkg::ST_IDLE;
          ov_nxt    = 1'b1;
          ores_nxt  = '0;
          ofnd_nxt  = 1'b0;
          odrp_nxt  = 1'b0;
        end else if (gt_v[mid_idx]) begin
          hi_nxt = mid - (CW+1)'(1);
        end else if (eq_v[mid_idx]) begin
          state_nxt = skt_pkg::ST_IDLE;
          ov_nxt    = 1'b1;
          ores_nxt  = cell_data[mid_idx].val;
          ofnd_nxt  = 1'b1;
          odrp_nxt  = 1'b0;
        end else begin
          lo_nxt = mid + (CW+1)'(1);
        end
      end
      default: begin
        state_nxt = skt_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skt_pkg::ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pass_r  <= pass_nxt;
    par_r   <= par_nxt;
    q_key_r <= q_key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    ores_r  <= ores_nxt;
    ofnd_r  <= ofnd_nxt;
    odrp_r  <= odrp_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_value = ores_r;
  assign out_found        = ofnd_r;
  assign out_full_dropped = odrp_r;

  // checks
  `SKT_ASSERT(a_cnt_bound, int'(cnt_r) <= CAP)
  `SKT_ASSERT(a_miss_zero, (ov_r && !ofnd_r) |-> (ores_r == '0))
  `SKT_ASSERT_NEVER(a_flags_excl, ov_r && ofnd_r && odrp_r)
  `SKT_ASSERT(a_accept_busy, accept |=> (ov_r || (state_r != skt_pkg::ST_IDLE)))
endmodule
